FILE: rtl/core/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg: shared definitions for the bilinear texture sampler
// Texture sizes, field widths, register indexes, sequencer states and the
// operand bundle of the shared multiply-add unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = 16;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 9;
    localparam int TEXEL_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int COORD_W    = 17;
    localparam int FRAC_W     = 16;

    // shared unit: res = x * y + z, x unsigned, y signed, z unsigned
    localparam int MAC_X_W    = 17;
    localparam int MAC_Y_W    = 10;
    localparam int MAC_Z_W    = 25;
    localparam int MAC_R_W    = 28;

    localparam logic [0:0] REG_TEX_WIDTH  = 1'b0;
    localparam logic [0:0] REG_TEX_HEIGHT = 1'b1;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] FETCH_LAST = 4'd5;
    localparam logic [STEP_W-1:0] BLEND_LAST = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE_X,
        ST_SCALE_Y,
        ST_SPLIT_Y,
        ST_FETCH,
        ST_BLEND
    } bts_state_t;

    typedef struct packed {
        logic        [MAC_X_W-1:0] x;
        logic signed [MAC_Y_W-1:0] y;
        logic        [MAC_Z_W-1:0] z;
    } mac_op_t;

endpackage

`default_nettype wire

FILE: rtl/core/bilinear_texture_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler: RGB888 texture store with bilinear sampling
// Writes fill a single-port texel memory; samples scale u and v by size-1,
// fetch four clamped neighbours and blend each channel in three truncating
// steps, all through one shared multiply-add unit.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   beat taken when
//  --------  ----------------------------------------  ----------------------
//  command   start, busy, action, texel_address,       start && !busy
//            write_red/green/blue, u_coord, v_coord
//  result    done, red_out, green_out, blue_out        done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
//  A write beat stores the texel at the accepting edge; busy never rises. A
//  sample keeps busy high through the scale and split states, the fetch state
//  that walks four reads through the one memory port and the blend state that
//  runs nine blends through the multiply-add unit; done pulses in the cycle
//  after busy falls and a new command may be taken in that same cycle.
//  Reset clears the sequencer and sets both sizes to 256; the texel memory is
//  not cleared. The receiver cannot stall, and cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_texture_sampler (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          action,
    input  wire logic [bts_pkg::ADDR_W-1:0]    texel_address,
    input  wire logic [bts_pkg::CHAN_W-1:0]    write_red,
    input  wire logic [bts_pkg::CHAN_W-1:0]    write_green,
    input  wire logic [bts_pkg::CHAN_W-1:0]    write_blue,
    input  wire logic [bts_pkg::COORD_W-1:0]   u_coord,
    input  wire logic [bts_pkg::COORD_W-1:0]   v_coord,
    // result
    output logic                               done,
    output logic [bts_pkg::CHAN_W-1:0]         red_out,
    output logic [bts_pkg::CHAN_W-1:0]         green_out,
    output logic [bts_pkg::CHAN_W-1:0]         blue_out,
    // configuration
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [bts_pkg::SIZE_W-1:0]    cfg_data
);
    import bts_pkg::*;

    // pick one 8-bit channel out of a packed texel: red, green, blue
    function automatic logic [CHAN_W-1:0] texel_chan(input logic [TEXEL_W-1:0] t,
                                                     input logic [1:0] c);
        logic [CHAN_W-1:0] r;
        case (c)
            2'd0:    r = t[23:16];
            2'd1:    r = t[15:8];
            default: r = t[7:0];
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] tex_width_reg;
    logic [SIZE_W-1:0] tex_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= SIZE_W'(MAX_WIDTH);
            tex_height_reg <= SIZE_W'(MAX_HEIGHT);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TEX_WIDTH:  tex_width_reg  <= cfg_data;
                REG_TEX_HEIGHT: tex_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Saturate the sizes into 1..MAX; zero counts as one.
    logic [SIZE_W-1:0] eff_w;
    logic [SIZE_W-1:0] eff_h;
    logic [COL_W-1:0]  w_m1;
    logic [ROW_W-1:0]  h_m1;

    always_comb
    begin
        if (tex_width_reg == '0)
            eff_w = SIZE_W'(1);
        else if (tex_width_reg > SIZE_W'(MAX_WIDTH))
            eff_w = SIZE_W'(MAX_WIDTH);
        else
            eff_w = tex_width_reg;

        if (tex_height_reg == '0)
            eff_h = SIZE_W'(1);
        else if (tex_height_reg > SIZE_W'(MAX_HEIGHT))
            eff_h = SIZE_W'(MAX_HEIGHT);
        else
            eff_h = tex_height_reg;
    end

    assign w_m1 = COL_W'(eff_w - SIZE_W'(1));
    assign h_m1 = ROW_W'(eff_h - SIZE_W'(1));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    bts_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic              done_reg,  done_next;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && action == ACT_SAMPLE)
                    state_next = ST_SCALE_X;
            end
            ST_SCALE_X: state_next = ST_SCALE_Y;
            ST_SCALE_Y: state_next = ST_SPLIT_Y;
            ST_SPLIT_Y:
            begin
                state_next = ST_FETCH;
                step_next  = '0;
            end
            ST_FETCH:
            begin
                if (step_reg == FETCH_LAST)
                begin
                    state_next = ST_BLEND;
                    step_next  = '0;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            ST_BLEND:
            begin
                if (step_reg == BLEND_LAST)
                begin
                    state_next = ST_IDLE;
                    step_next  = '0;
                    done_next  = 1'b1;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sample datapath registers
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] u_reg, v_reg;
    logic [FRAC_W-1:0]  fx_reg, fy_reg;
    logic [COL_W-1:0]   x0_reg, x1_reg;
    logic [ROW_W-1:0]   y0_reg, y1_reg;
    logic [TEXEL_W-1:0] tex_reg [0:3];
    logic [CHAN_W-1:0]  mid_reg [0:5];
    logic [CHAN_W-1:0]  red_reg, green_reg, blue_reg;
    logic [TEXEL_W-1:0] rd_data_reg;

    logic signed [MAC_R_W-1:0] mac_res;
    mac_op_t                   mac_op;

    // Split a scaled coordinate into index and fraction; clamp both neighbours.
    logic [SIZE_W-1:0]  ix, iy;
    logic [SIZE_W:0]    ix1, iy1;
    logic [COL_W-1:0]   x0_calc, x1_calc;
    logic [ROW_W-1:0]   y0_calc, y1_calc;

    assign ix  = mac_res[FRAC_W + SIZE_W - 1:FRAC_W];
    assign iy  = mac_res[FRAC_W + SIZE_W - 1:FRAC_W];
    assign ix1 = {1'b0, ix} + (SIZE_W + 1)'(1);
    assign iy1 = {1'b0, iy} + (SIZE_W + 1)'(1);

    always_comb
    begin
        x0_calc = (ix  >= SIZE_W'(w_m1))       ? w_m1 : ix[COL_W-1:0];
        x1_calc = (ix1 >= (SIZE_W + 1)'(w_m1)) ? w_m1 : ix1[COL_W-1:0];
        y0_calc = (iy  >= SIZE_W'(h_m1))       ? h_m1 : iy[ROW_W-1:0];
        y1_calc = (iy1 >= (SIZE_W + 1)'(h_m1)) ? h_m1 : iy1[ROW_W-1:0];
    end

    // Step bookkeeping: fetch lands texel k-2, blend lands result k-1.
    logic [STEP_W-1:0] tex_idx;
    logic [STEP_W-1:0] res_idx;
    assign tex_idx = step_reg - STEP_W'(2);
    assign res_idx = step_reg - STEP_W'(1);

    always_ff @(posedge clk)
    begin
        if (accept && action == ACT_SAMPLE)
        begin
            u_reg <= u_coord;
            v_reg <= v_coord;
        end
        if (state_reg == ST_SCALE_Y)
        begin
            fx_reg <= mac_res[FRAC_W-1:0];
            x0_reg <= x0_calc;
            x1_reg <= x1_calc;
        end
        if (state_reg == ST_SPLIT_Y)
        begin
            fy_reg <= mac_res[FRAC_W-1:0];
            y0_reg <= y0_calc;
            y1_reg <= y1_calc;
        end
        if (state_reg == ST_FETCH && step_reg >= STEP_W'(2))
            tex_reg[tex_idx[1:0]] <= rd_data_reg;
        if (state_reg == ST_BLEND && step_reg != '0)
        begin
            // blend results sit in bits 23:16 of the sum
            if (res_idx < STEP_W'(6))
                mid_reg[res_idx[2:0]] <= mac_res[23:16];
            else if (res_idx == STEP_W'(6))
                red_reg <= mac_res[23:16];
            else if (res_idx == STEP_W'(7))
                green_reg <= mac_res[23:16];
            else
                blue_reg <= mac_res[23:16];
        end
    end

    // ------------------------------------------------------------------
    // Operand selection for the shared multiply-add unit
    // ------------------------------------------------------------------
    logic [1:0]        blend_ch;
    logic [STEP_W-1:0] fin_step;
    logic [CHAN_W-1:0] lerp_a, lerp_b;
    logic [FRAC_W-1:0] lerp_f;
    logic [ROW_W-1:0]  fetch_row;
    logic [COL_W-1:0]  fetch_col;

    assign fin_step  = step_reg - STEP_W'(6);
    assign fetch_row = step_reg[1] ? y1_reg : y0_reg;
    assign fetch_col = step_reg[0] ? x1_reg : x0_reg;

    always_comb
    begin
        if (step_reg < STEP_W'(6))
        begin
            // horizontal pass: even steps blend the top row, odd the bottom
            blend_ch = step_reg[2:1];
            lerp_a   = texel_chan(step_reg[0] ? tex_reg[2] : tex_reg[0], blend_ch);
            lerp_b   = texel_chan(step_reg[0] ? tex_reg[3] : tex_reg[1], blend_ch);
            lerp_f   = fx_reg;
        end
        else
        begin
            // vertical pass between the two row results of one channel
            blend_ch = fin_step[1:0];
            lerp_a   = mid_reg[{blend_ch, 1'b0}];
            lerp_b   = mid_reg[{blend_ch, 1'b1}];
            lerp_f   = fy_reg;
        end
    end

    always_comb
    begin
        mac_op.x = '0;
        mac_op.y = '0;
        mac_op.z = '0;
        case (state_reg)
            ST_SCALE_X:
            begin
                mac_op.x = u_reg;
                mac_op.y = $signed({{(MAC_Y_W - COL_W){1'b0}}, w_m1});
            end
            ST_SCALE_Y:
            begin
                mac_op.x = v_reg;
                mac_op.y = $signed({{(MAC_Y_W - ROW_W){1'b0}}, h_m1});
            end
            ST_FETCH:
            begin
                // address = row * width + column
                mac_op.x = {{(MAC_X_W - ROW_W){1'b0}}, fetch_row};
                mac_op.y = $signed({{(MAC_Y_W - SIZE_W){1'b0}}, eff_w});
                mac_op.z = {{(MAC_Z_W - COL_W){1'b0}}, fetch_col};
            end
            ST_BLEND:
            begin
                // a * 65536 + (b - a) * f
                mac_op.x = {{(MAC_X_W - FRAC_W){1'b0}}, lerp_f};
                mac_op.y = $signed({2'b00, lerp_b}) - $signed({2'b00, lerp_a});
                mac_op.z = {1'b0, lerp_a, {FRAC_W{1'b0}}};
            end
            default: ;
        endcase
    end

    bts_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .res (mac_res)
    );

    // ------------------------------------------------------------------
    // Texel memory: one port, write on a write beat, read during fetch
    // ------------------------------------------------------------------
    logic [TEXEL_W-1:0] texel_mem [0:MEM_DEPTH-1];
    logic               mem_we;
    logic               mem_re;

    assign mem_we = accept && action == ACT_WRITE;
    assign mem_re = state_reg == ST_FETCH && step_reg >= STEP_W'(1)
                    && step_reg <= STEP_W'(4);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            texel_mem[texel_address] <= {write_red, write_green, write_blue};
        else if (mem_re)
            rd_data_reg <= texel_mem[mac_res[ADDR_W-1:0]];
    end

    // ------------------------------------------------------------------
    // Result beat
    // ------------------------------------------------------------------
    assign done      = done_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bts_mac.sv
// ----------------------------------------------------------------------------
// bts_mac: shared multiply-add unit
// One signed multiply and one add per cycle, result registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_mac (
    input  wire logic                                  clk,
    input  wire bts_pkg::mac_op_t                      op,
    output logic signed [bts_pkg::MAC_R_W-1:0]         res
);
    import bts_pkg::*;

    logic signed [MAC_R_W-1:0] prod;
    logic signed [MAC_R_W-1:0] sum;
    logic signed [MAC_R_W-1:0] res_reg;

    assign prod = $signed({1'b0, op.x}) * op.y;
    assign sum  = prod + $signed({{(MAC_R_W - MAC_Z_W){1'b0}}, op.z});

    always_ff @(posedge clk)
    begin
        res_reg <= sum;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: sim/bilinear_texture_sampler_tb.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_tb: self-checking bench for the bilinear sampler
// Fills the texture through write beats and checks every sample result,
// channel by channel, against a local bilinear predictor or a hand-typed
// expectation. The bench steps through a series of texture sizes: single
// texel, thin strips, full store and saturating register values. A directed
// table opens the run and random traffic with bursty issue follows.
// ----------------------------------------------------------------------------

module bilinear_texture_sampler_tb;

    import bts_pkg::*;

    localparam int TIMEOUT      = 5_000_000;
    localparam int PHASES       = 10;
    localparam int BEATS_EACH   = 170;
    localparam int MAX_REPORTS  = 10;

    // one texel as stored: red in the top byte, blue in the bottom byte
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } texel_t;

    // one command beat, plus an optional hand-typed expectation
    typedef struct packed {
        logic               act;
        logic [ADDR_W-1:0]  addr;
        texel_t             colour;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        logic               typed;
        texel_t             want;
    } command_t;

    // four neighbour addresses of a sample and its two fractions
    typedef struct packed {
        logic [ADDR_W-1:0] a00;
        logic [ADDR_W-1:0] a10;
        logic [ADDR_W-1:0] a01;
        logic [ADDR_W-1:0] a11;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } footprint_t;

    // ------------------------------------------------------------------------
    // Directed table, walked at reset sizes (256 x 256). Expected colours are
    // typed only where, on each axis, the fraction vanishes or both neighbours
    // coincide; every other sample row goes to the predictor.
    // ------------------------------------------------------------------------
    localparam int DIRECTED_ROWS = 20;
    localparam command_t DIRECTED [DIRECTED_ROWS] = '{
        //  act         addr      colour      u          v          typed want
        '{ACT_WRITE,  16'h0000, 24'hFF0080, 17'h00000, 17'h00000, 1'b0, 24'h000000},
        '{ACT_WRITE,  16'h0001, 24'h00FF7F, 17'h00000, 17'h00000, 1'b0, 24'h000000},
        '{ACT_WRITE,  16'h0100, 24'h102030, 17'h00000, 17'h00000, 1'b0, 24'h000000},
        '{ACT_WRITE,  16'h0101, 24'hFFFFFF, 17'h00000, 17'h00000, 1'b0, 24'h000000},
        '{ACT_SAMPLE, 16'h0000, 24'h000000, 17'h00000, 17'h00000, 1'b1, 24'hFF0080},
        '{ACT_SAMPLE, 16'h0000, 24'h000000, 17'h00001, 17'h00000, 1'b0, 24'h000000},
        '{ACT_SAMPLE, 16'h0000, 24'h000000, 17'h00100, 17'h00100, 1'b0, 24'h000000},
        '{ACT_WRITE,  16'hFFFF, 24'h010203, 17'h00000, 17'h00000, 1'b0, 24'h000000},
        '{ACT_SAMPLE, 16'h0000, 24'h000000, 17'h10000, 17'h10000, 1'b1, 24'h010203},
        '{ACT_SAMPLE, 16'h0000, 24'h000000, 17'h1FFFF, 17'h1FFFF, 1'b1, 24'h010203},
        '{ACT_WRITE,  16'hFF00, 24'h00FF00, 17'h00000, 17'h00000, 1'b0, 24'h000000},
        '{ACT_WRITE,  16'hFF01, 24'h0000FF, 17'h00000, 17'h00000, 1'b0, 24'h000000},
        '{ACT_SAMPLE, 16'h0000, 24'h000000, 17'h00000, 17'h1FFFF, 1'b1, 24'h00FF00},
        '{ACT_WRITE,  16'hFFFE, 24'h808080, 17'h00000, 17'h00000, 1'b0, 24'h000000},
        '{ACT_WRITE,  16'hFEFE, 24'h000000, 17'h00000, 17'h00000, 1'b0, 24'h000000},
        '{ACT_WRITE,  16'hFEFF, 24'hFFFFFF, 17'h00000, 17'h00000, 1'b0, 24'h000000},
        '{ACT_SAMPLE, 16'h0000, 24'h000000, 17'h0FFFF, 17'h0FFFF, 1'b0, 24'h000000},
        '{ACT_WRITE,  16'h00FF, 24'hAA55CC, 17'h00000, 17'h00000, 1'b0, 24'h000000},
        '{ACT_WRITE,  16'h01FF, 24'h123456, 17'h00000, 17'h00000, 1'b0, 24'h000000},
        '{ACT_SAMPLE, 16'h0000, 24'h000000, 17'h1FFFF, 17'h00000, 1'b1, 24'hAA55CC}
    };

    // clock and reset; every block input starts at a known value
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                start         = 1'b0;
    logic                action        = ACT_WRITE;
    logic [ADDR_W-1:0]   texel_address = '0;
    logic [CHAN_W-1:0]   write_red     = '0;
    logic [CHAN_W-1:0]   write_green   = '0;
    logic [CHAN_W-1:0]   write_blue    = '0;
    logic [COORD_W-1:0]  u_coord       = '0;
    logic [COORD_W-1:0]  v_coord       = '0;
    logic                cfg_valid     = 1'b0;
    logic [0:0]          cfg_index     = REG_TEX_WIDTH;
    logic [SIZE_W-1:0]   cfg_data      = '0;

    logic                busy;
    logic                done;
    logic                cfg_ready;
    logic [CHAN_W-1:0]   red_out;
    logic [CHAN_W-1:0]   green_out;
    logic [CHAN_W-1:0]   blue_out;

    always #5 clk = ~clk;

    bilinear_texture_sampler dut (.*);

    // ------------------------------------------------------------------------
    // Local copy of the block's state: the size registers as written, the
    // texture contents and which texels hold a defined value.
    // ------------------------------------------------------------------------
    logic [SIZE_W-1:0] width_reg  = SIZE_W'(MAX_WIDTH);
    logic [SIZE_W-1:0] height_reg = SIZE_W'(MAX_HEIGHT);
    texel_t            shadow_texels [0:MEM_DEPTH-1];
    bit                texel_written [0:MEM_DEPTH-1];

    texel_t awaited_texels [$];

    int faults        = 0;
    int results_seen  = 0;
    int beats_sent    = 0;
    int writes_sent   = 0;
    int samples_sent  = 0;
    int size_settings = 0;
    int burst_left    = 4;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // zero reads as one, anything past the store saturates
    function automatic int clamp_size(logic [SIZE_W-1:0] r, int limit);
        if (r == 0)
            return 1;
        if (int'(r) > limit)
            return limit;
        return int'(r);
    endfunction

    // scale by size-1, split into index and fraction, clamp both neighbours
    function automatic footprint_t footprint(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        footprint_t fp;
        int cols, rows, xs, ys, ix, iy, x0, x1, y0, y1;
        cols  = clamp_size(width_reg, MAX_WIDTH);
        rows  = clamp_size(height_reg, MAX_HEIGHT);
        xs    = int'(u) * (cols - 1);
        ys    = int'(v) * (rows - 1);
        fp.fx = xs[FRAC_W-1:0];
        fp.fy = ys[FRAC_W-1:0];
        ix    = xs >> FRAC_W;
        iy    = ys >> FRAC_W;
        x0    = (ix >= cols - 1)     ? cols - 1 : ix;
        x1    = (ix + 1 >= cols - 1) ? cols - 1 : ix + 1;
        y0    = (iy >= rows - 1)     ? rows - 1 : iy;
        y1    = (iy + 1 >= rows - 1) ? rows - 1 : iy + 1;
        fp.a00 = ADDR_W'(y0 * cols + x0);
        fp.a10 = ADDR_W'(y0 * cols + x1);
        fp.a01 = ADDR_W'(y1 * cols + x0);
        fp.a11 = ADDR_W'(y1 * cols + x1);
        return fp;
    endfunction

    // floor((a*65536 + (b-a)*f) / 65536); never negative for 8-bit a, b
    function automatic logic [CHAN_W-1:0] lerp_trunc(logic [CHAN_W-1:0] a,
                                                     logic [CHAN_W-1:0] b,
                                                     logic [FRAC_W-1:0] f);
        longint num;
        num = (longint'(a) <<< FRAC_W) + (longint'(b) - longint'(a)) * longint'(f);
        return num[FRAC_W+CHAN_W-1:FRAC_W];
    endfunction

    // horizontal on both rows, then vertical, truncating after each step
    function automatic texel_t predict_colour(logic [COORD_W-1:0] u,
                                              logic [COORD_W-1:0] v);
        footprint_t fp;
        texel_t t00, t10, t01, t11, res;
        fp  = footprint(u, v);
        t00 = shadow_texels[fp.a00];
        t10 = shadow_texels[fp.a10];
        t01 = shadow_texels[fp.a01];
        t11 = shadow_texels[fp.a11];
        res.red   = lerp_trunc(lerp_trunc(t00.red, t10.red, fp.fx),
                               lerp_trunc(t01.red, t11.red, fp.fx), fp.fy);
        res.green = lerp_trunc(lerp_trunc(t00.green, t10.green, fp.fx),
                               lerp_trunc(t01.green, t11.green, fp.fx), fp.fy);
        res.blue  = lerp_trunc(lerp_trunc(t00.blue, t10.blue, fp.fx),
                               lerp_trunc(t01.blue, t11.blue, fp.fx), fp.fy);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Beat builders and random picks
    // ------------------------------------------------------------------------

    function automatic command_t write_cmd(logic [ADDR_W-1:0] addr, texel_t colour);
        command_t c;
        c        = '0;
        c.act    = ACT_WRITE;
        c.addr   = addr;
        c.colour = colour;
        return c;
    endfunction

    function automatic command_t sample_cmd(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        command_t c;
        c     = '0;
        c.act = ACT_SAMPLE;
        c.u   = u;
        c.v   = v;
        return c;
    endfunction

    // bias towards the edges: exactly 0, exactly 1.0, and past 1.0
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COORD_W'(1 << FRAC_W);
            2:       return COORD_W'($urandom_range((1 << FRAC_W) + 1, (1 << COORD_W) - 1));
            default: return COORD_W'($urandom_range(0, (1 << FRAC_W) - 1));
        endcase
    endfunction

    task automatic note_fault(input string what);
        faults++;
        if (faults <= MAX_REPORTS)
            $display("%0t mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Present one beat and hold it until taken (start high, busy low at the
    // edge). Update the local state at that edge, then either keep start up
    // for the next beat of the burst or drop it for a random gap.
    task automatic issue(input command_t c);
        start         <= 1'b1;
        action        <= c.act;
        texel_address <= c.addr;
        write_red     <= c.colour.red;
        write_green   <= c.colour.green;
        write_blue    <= c.colour.blue;
        u_coord       <= c.u;
        v_coord       <= c.v;
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
        if (c.act == ACT_WRITE)
        begin
            shadow_texels[c.addr] = c.colour;
            texel_written[c.addr] = 1'b1;
            writes_sent++;
        end
        else
        begin
            awaited_texels.push_back(c.typed ? c.want : predict_colour(c.u, c.v));
            samples_sent++;
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Write any neighbour that holds no defined texel yet, then sample.
    task automatic sample_at(input command_t c);
        footprint_t        fp;
        logic [ADDR_W-1:0] corner [4];
        fp     = footprint(c.u, c.v);
        corner = '{fp.a00, fp.a10, fp.a01, fp.a11};
        foreach (corner[k])
            if (!texel_written[corner[k]])
                issue(write_cmd(corner[k], texel_t'($urandom)));
        issue(c);
    endtask

    // Drop start and wait until every sample result is back and the block is
    // idle; always let at least one edge pass so start is not driven twice.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (awaited_texels.size() != 0 || busy);
    endtask

    // Write both size registers back to back; hold valid across the pair.
    task automatic set_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= REG_TEX_WIDTH;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        width_reg = w;
        cfg_index <= REG_TEX_HEIGHT;
        cfg_data  <= h;
        do
            @(posedge clk);
        while (!cfg_ready);
        height_reg = h;
        cfg_valid <= 1'b0;
        size_settings++;
    endtask

    // One random beat: mostly samples, some re-texturing inside the region in
    // use, a little noise anywhere in the store, and the odd full drain.
    task automatic random_beat();
        int cols, rows, pick;
        cols = clamp_size(width_reg, MAX_WIDTH);
        rows = clamp_size(height_reg, MAX_HEIGHT);
        pick = $urandom_range(0, 99);
        if (pick < 68)
            sample_at(sample_cmd(pick_coord(), pick_coord()));
        else if (pick < 88)
            issue(write_cmd(ADDR_W'($urandom_range(0, rows - 1) * cols
                                   + $urandom_range(0, cols - 1)),
                            texel_t'($urandom)));
        else
            issue(write_cmd(ADDR_W'($urandom), texel_t'($urandom)));
        if ($urandom_range(0, 59) == 0)
            drain();
    endtask

    // ------------------------------------------------------------------------
    // Result side: the receiver cannot stall, so take every done pulse and
    // match it against the oldest outstanding sample.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        texel_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (awaited_texels.size() == 0)
                note_fault($sformatf("result rgb %02h %02h %02h with no sample outstanding",
                                     red_out, green_out, blue_out));
            else
            begin
                want = awaited_texels.pop_front();
                if (red_out !== want.red || green_out !== want.green ||
                    blue_out !== want.blue)
                    note_fault($sformatf("result %0d: expected rgb %02h %02h %02h, got %02h %02h %02h",
                                         results_seen, want.red, want.green, want.blue,
                                         red_out, green_out, blue_out));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [SIZE_W-1:0] pw, ph;
        // hold reset, then release it on an edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
            begin
                // directed table at reset sizes
                for (int row = 0; row < DIRECTED_ROWS; row++)
                    if (DIRECTED[row].act == ACT_SAMPLE)
                        sample_at(DIRECTED[row]);
                    else
                        issue(DIRECTED[row]);
            end
            else
            begin
                // reconfigure only once idle; allow for a trailing write
                drain();
                repeat (4) @(posedge clk);
                case (phase)
                    1:       begin pw = 9'd0;   ph = 9'd0;   end
                    2:       begin pw = 9'd1;   ph = 9'd256; end
                    3:       begin pw = 9'd2;   ph = 9'd2;   end
                    4:       begin pw = 9'd257; ph = 9'd511; end
                    5:       begin pw = 9'd511; ph = 9'd0;   end
                    6:
                    begin
                        pw = SIZE_W'($urandom_range(3, 24));
                        ph = SIZE_W'($urandom_range(3, 24));
                    end
                    7:
                    begin
                        pw = SIZE_W'($urandom_range(0, 511));
                        ph = SIZE_W'($urandom_range(0, 511));
                    end
                    8:       begin pw = 9'd256; ph = 9'd3;   end
                    default:
                    begin
                        pw = SIZE_W'($urandom_range(2, 16));
                        ph = SIZE_W'($urandom_range(2, 16));
                    end
                endcase
                set_size(pw, ph);
            end
            while (beats_sent < BEATS_EACH * (phase + 1))
                random_beat();
        end

        // let the last results arrive, then a little slack for stray pulses
        drain();
        repeat (30) @(posedge clk);
        if (awaited_texels.size() != 0)
            note_fault($sformatf("%0d sample results never arrived", awaited_texels.size()));

        $display("Run covered %0d texel writes and %0d samples (%0d results checked)",
                 writes_sent, samples_sent, results_seen);
        $display("over %0d size settings, with %0d faults found", size_settings + 1, faults);
        if (faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog: generous multiple of the slowest legal run
    initial
    begin
        #(TIMEOUT);
        $display("Timed out with %0d sample results outstanding", awaited_texels.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/bts_pkg.sv
rtl/core/bts_mac.sv
rtl/core/bilinear_texture_sampler.sv
sim/bilinear_texture_sampler_tb.sv
